// ===== rtl/sttb_pkg.sv =====
package sttb_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int NUM_TASKS  = 8;
	localparam int NUM_SLOTS  = NUM_TIMERS + NUM_TASKS;
	localparam int IDX_W      = $clog2(NUM_SLOTS);
	localparam int COUNT_W    = 20;
	localparam int PERIOD_W   = 16;
	localparam int SLOT_W     = 3;
	localparam int ACTION_W   = 3;
	// wide enough for a slot index plus the timer count
	localparam int EXT_W      = 7;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK        = 3'd0,
		ACT_START_TIMER = 3'd1,
		ACT_STOP_TIMER  = 3'd2,
		ACT_START_TASK  = 3'd3,
		ACT_STOP_TASK   = 3'd4
	} action_t;

	typedef enum logic {
		ALU_SCALE,
		ALU_DEC
	} alu_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [COUNT_W-1:0] value;
		logic               is_zero;
	} alu_res_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              is_task;
		logic              last;
	} expiry_t;

	typedef struct packed {
		logic    push;
		expiry_t item;
	} out_push_t;

endpackage

// ===== rtl/sttb_cmd_if.sv =====
interface sttb_cmd_if;
	import sttb_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [SLOT_W-1:0]   slot;
	logic [PERIOD_W-1:0] period_ms;
	logic                repeat_req;

	modport source (output valid, action, slot, period_ms, repeat_req, input ready);
	modport sink (input valid, action, slot, period_ms, repeat_req, output ready);

endinterface

// ===== rtl/sttb_exp_if.sv =====
interface sttb_exp_if;
	import sttb_pkg::*;

	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] expired_slot;
	logic              expired_is_task;
	logic              last_expiry;

	modport source (output valid, expired_slot, expired_is_task, last_expiry, input ready);
	modport sink (input valid, expired_slot, expired_is_task, last_expiry, output ready);

endinterface

// ===== rtl/sttb_alu.sv =====
module sttb_alu (
	input  sttb_pkg::alu_op_t                 op,
	input  logic [sttb_pkg::COUNT_W-1:0]      a,
	output sttb_pkg::alu_res_t                res
);
	import sttb_pkg::*;

	logic [COUNT_W-1:0] x;
	logic [COUNT_W-1:0] y;
	logic [COUNT_W-1:0] sum;

	// one adder: a - 1 for countdown, 8a + 2a for the ms to tenths scale
	always_comb begin
		if (op == ALU_DEC) begin
			x = a;
			y = '1;
		end else begin
			x = a << 3;
			y = a << 1;
		end
		sum         = x + y;
		res.value   = sum;
		res.is_zero = (sum == '0);
	end

endmodule

// ===== rtl/sttb_out_reg.sv =====
module sttb_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sttb_pkg::out_push_t  push_in,
	output logic                 can_push,
	sttb_exp_if.source           exp
);
	import sttb_pkg::*;

	logic    valid_q;
	expiry_t data_q;

	assign can_push = !valid_q || exp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_push) begin
			valid_q <= push_in.push;
		end
	end

	always_ff @(posedge clk) begin
		if (can_push && push_in.push) begin
			data_q <= push_in.item;
		end
	end

	assign exp.valid           = valid_q;
	assign exp.expired_slot    = data_q.slot;
	assign exp.expired_is_task = data_q.is_task;
	assign exp.last_expiry     = data_q.last;

endmodule

// ===== rtl/software_timer_and_task_bank_unit.sv =====
// Bank of NUM_TIMERS timer slots and NUM_TASKS periodic task slots, counted in
// 0.1 ms ticks. A start command or a stop command leaves the command side ready.
// A tick walks every slot in turn through one shared decrement unit, timers
// first, then tasks, one slot a cycle while no full expiry register holds the
// walk, and reports each slot that reaches zero as an expiry request; the final
// request of a tick carries last_expiry. A flush state follows the walk and
// hands out the held expiry; the walk and the flush both wait for a full expiry
// register to empty. The command side is ready only between ticks. A zero
// period never fires, and a start or stop naming a slot beyond the bank is
// dropped.
module software_timer_and_task_bank_unit (
	input  logic        clk,
	input  logic        arst_n,
	sttb_cmd_if.sink    cmd,
	sttb_exp_if.source  exp
);
	import sttb_pkg::*;

	// sequencer
	state_t state_q;
	state_t state_d;
	logic [IDX_W-1:0] walk_q;

	// per-slot state, timers at the low indexes, tasks above them
	logic [COUNT_W-1:0] count_q  [NUM_SLOTS];
	logic [COUNT_W-1:0] reload_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] act_q;
	logic [NUM_SLOTS-1:0] rep_q;

	// expiry held back until we know whether another one follows
	logic    pend_v_q;
	expiry_t pend_q;

	// shared unit
	alu_op_t            alu_op;
	logic [COUNT_W-1:0] alu_a;
	alu_res_t           alu_res;

	out_push_t push;
	logic      can_push;

	// command decode
	logic             cmd_acc;
	action_t          act_code;
	logic [EXT_W-1:0] slot_ext;
	logic             timer_ok;
	logic             task_ok;
	logic [IDX_W-1:0] tmr_sel;
	logic [IDX_W-1:0] tsk_sel;

	// walk decode
	logic [COUNT_W-1:0] cur_cnt;
	logic               cur_act;
	logic               cur_rep;
	logic               live;
	logic               hit;
	logic               stall;
	logic               step;
	logic               last_idx;
	logic               walk_is_task;
	expiry_t            walk_item;

	sttb_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.res (alu_res)
	);

	sttb_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_in  (push),
		.can_push (can_push),
		.exp      (exp)
	);

	always_comb begin
		act_code = action_t'(cmd.action);
		cmd_acc  = cmd.valid && cmd.ready;
		slot_ext = EXT_W'(cmd.slot);
		timer_ok = slot_ext < EXT_W'(NUM_TIMERS);
		task_ok  = slot_ext < EXT_W'(NUM_TASKS);
		tmr_sel  = IDX_W'(slot_ext);
		tsk_sel  = IDX_W'(slot_ext + EXT_W'(NUM_TIMERS));
	end

	always_comb begin
		cur_cnt      = count_q[walk_q];
		cur_act      = act_q[walk_q];
		cur_rep      = rep_q[walk_q];
		// only a live slot decrements, and it fires when the new count is zero
		live         = cur_act && (cur_cnt != '0);
		hit          = live && alu_res.is_zero;
		// a second expiry needs the held one moved out first
		stall        = hit && pend_v_q && !can_push;
		step         = (state_q == ST_WALK) && !stall;
		last_idx     = walk_q == IDX_W'(NUM_SLOTS - 1);
		walk_is_task = walk_q >= IDX_W'(NUM_TIMERS);
		walk_item.slot    = walk_is_task ? SLOT_W'(walk_q - IDX_W'(NUM_TIMERS))
		                                 : SLOT_W'(walk_q);
		walk_item.is_task = walk_is_task;
		walk_item.last    = 1'b0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_acc && act_code == ACT_TICK) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (step && last_idx) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!pend_v_q || can_push) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd.ready = 1'b0;
		alu_op    = ALU_SCALE;
		alu_a     = COUNT_W'(cmd.period_ms);
		push.push = 1'b0;
		push.item = pend_q;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
			end
			ST_WALK: begin
				alu_op    = ALU_DEC;
				alu_a     = cur_cnt;
				push.push = step && hit && pend_v_q;
			end
			ST_FLUSH: begin
				push.push      = pend_v_q && can_push;
				push.item.last = 1'b1;
			end
			default: begin
				cmd.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			walk_q   <= '0;
			pend_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				walk_q <= '0;
			end else if (step) begin
				walk_q <= walk_q + 1'b1;
			end
			if (step && hit) begin
				pend_v_q <= 1'b1;
			end else if (state_q == ST_FLUSH && can_push) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && hit) begin
			pend_q <= walk_item;
		end
	end

	// active and repeat flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
			rep_q <= '0;
		end else if (cmd_acc) begin
			case (act_code)
				ACT_START_TIMER: begin
					if (timer_ok) begin
						act_q[tmr_sel] <= 1'b1;
						rep_q[tmr_sel] <= cmd.repeat_req;
					end
				end
				ACT_STOP_TIMER: begin
					if (timer_ok) begin
						act_q[tmr_sel] <= 1'b0;
						rep_q[tmr_sel] <= 1'b0;
					end
				end
				ACT_START_TASK: begin
					// tasks always reload
					if (task_ok) begin
						act_q[tsk_sel] <= 1'b1;
						rep_q[tsk_sel] <= 1'b1;
					end
				end
				ACT_STOP_TASK: begin
					if (task_ok) begin
						act_q[tsk_sel] <= 1'b0;
					end
				end
				default: begin
					act_q <= act_q;
				end
			endcase
		end else if (step && hit && !cur_rep) begin
			// one-shot timer done
			act_q[walk_q] <= 1'b0;
		end
	end

	// counts and reload values, loaded by a start, stepped by the walk
	always_ff @(posedge clk) begin
		if (cmd_acc && act_code == ACT_START_TIMER && timer_ok) begin
			count_q[tmr_sel]  <= alu_res.value;
			reload_q[tmr_sel] <= alu_res.value;
		end else if (cmd_acc && act_code == ACT_START_TASK && task_ok) begin
			count_q[tsk_sel]  <= alu_res.value;
			reload_q[tsk_sel] <= alu_res.value;
		end else if (step && live) begin
			count_q[walk_q] <= (hit && cur_rep) ? reload_q[walk_q] : alu_res.value;
		end
	end

endmodule

// ===== rtl/sttb_checker.sv =====
module sttb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_valid,
	input logic                          cmd_ready,
	input logic [sttb_pkg::ACTION_W-1:0] cmd_action,
	input logic                          exp_valid,
	input logic                          exp_ready,
	input logic [sttb_pkg::SLOT_W-1:0]   exp_slot,
	input logic                          exp_is_task,
	input logic                          exp_last
);
	import sttb_pkg::*;

	// a waiting expiry request holds still
	a_exp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		exp_valid && !exp_ready |=>
			exp_valid && $stable(exp_slot) && $stable(exp_is_task) && $stable(exp_last))
		else $error("expiry request changed while stalled");

	// a tick starts a walk, so the command side closes
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_action == ACT_TICK |=> !cmd_ready)
		else $error("command side open right after a tick");

	// start and stop leave the command side open
	a_cmd_quick: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_action != ACT_TICK |=> cmd_ready)
		else $error("command side closed after a start or stop");

	// a non-final expiry means the tick is still in progress
	a_tick_open: assert property (@(posedge clk) disable iff (!arst_n)
		exp_valid && !exp_last |-> !cmd_ready)
		else $error("command side open before the final expiry of a tick");

endmodule

bind software_timer_and_task_bank_unit sttb_checker u_sttb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.cmd_action  (cmd.action),
	.exp_valid   (exp.valid),
	.exp_ready   (exp.ready),
	.exp_slot    (exp.expired_slot),
	.exp_is_task (exp.expired_is_task),
	.exp_last    (exp.last_expiry)
);

// ===== verif/tb_software_timer_and_task_bank_unit.sv =====
module tb_software_timer_and_task_bank_unit;
	import sttb_pkg::*;

	localparam int TENTHS_PER_MS = 10;
	localparam int QUIET_LIMIT   = 4000;
	localparam int RANDOM_ITEMS  = 310;
	localparam int SETTLE_CYCLES = 3 * (NUM_SLOTS + 2);
	localparam int STALL_PCT     = 13;

	// tracks the slot bank and holds the expiries each tick should report
	class expiry_scoreboard;
		bit [COUNT_W-1:0] timer_count  [NUM_TIMERS];
		bit [COUNT_W-1:0] timer_reload [NUM_TIMERS];
		bit               timer_active [NUM_TIMERS];
		bit               timer_repeat [NUM_TIMERS];
		bit [COUNT_W-1:0] task_count   [NUM_TASKS];
		bit [COUNT_W-1:0] task_reload  [NUM_TASKS];
		bit               task_active  [NUM_TASKS];
		expiry_t          pending_expiries [$];
		int               errors;
		int               checked;
		int               ticks;
		int               commands;
		int               widest_tick;

		function void note_request(logic [ACTION_W-1:0] act, logic [SLOT_W-1:0] slot,
				logic [PERIOD_W-1:0] period, logic rep);
			bit [31:0]        wide;
			bit [COUNT_W-1:0] tenths;
			int               first;
			expiry_t          hit;
			wide   = 32'(period) * TENTHS_PER_MS;
			tenths = wide[COUNT_W-1:0];
			first  = pending_expiries.size();
			case (act)
				ACT_TICK: begin
					ticks++;
					// timers first, then tasks, each in ascending slot order
					for (int i = 0; i < NUM_TIMERS; i++) begin
						if (timer_active[i] && timer_count[i] != '0) begin
							timer_count[i] = timer_count[i] - 1'b1;
							if (timer_count[i] == '0) begin
								hit.slot    = SLOT_W'(i);
								hit.is_task = 1'b0;
								hit.last    = 1'b0;
								pending_expiries.push_back(hit);
								if (timer_repeat[i])
									timer_count[i] = timer_reload[i];
								else
									timer_active[i] = 1'b0;
							end
						end
					end
					for (int i = 0; i < NUM_TASKS; i++) begin
						if (task_active[i] && task_count[i] != '0) begin
							task_count[i] = task_count[i] - 1'b1;
							if (task_count[i] == '0) begin
								hit.slot    = SLOT_W'(i);
								hit.is_task = 1'b1;
								hit.last    = 1'b0;
								pending_expiries.push_back(hit);
								task_count[i] = task_reload[i];
							end
						end
					end
					// final expiry of the tick carries the last flag
					if (pending_expiries.size() > first) begin
						hit      = pending_expiries.pop_back();
						hit.last = 1'b1;
						pending_expiries.push_back(hit);
						if (pending_expiries.size() - first > widest_tick)
							widest_tick = pending_expiries.size() - first;
					end
				end
				ACT_START_TIMER: begin
					commands++;
					if (int'(slot) < NUM_TIMERS) begin
						timer_reload[slot] = tenths;
						timer_count[slot]  = tenths;
						timer_active[slot] = 1'b1;
						timer_repeat[slot] = rep;
					end
				end
				ACT_STOP_TIMER: begin
					commands++;
					if (int'(slot) < NUM_TIMERS) begin
						timer_active[slot] = 1'b0;
						timer_repeat[slot] = 1'b0;
					end
				end
				ACT_START_TASK: begin
					commands++;
					if (int'(slot) < NUM_TASKS) begin
						task_reload[slot] = tenths;
						task_count[slot]  = tenths;
						task_active[slot] = 1'b1;
					end
				end
				ACT_STOP_TASK: begin
					commands++;
					if (int'(slot) < NUM_TASKS)
						task_active[slot] = 1'b0;
				end
				default: begin
					// unknown actions leave the bank untouched
				end
			endcase
		endfunction

		function void check_expiry(logic [SLOT_W-1:0] slot, logic is_task, logic last);
			expiry_t want;
			if (pending_expiries.size() == 0) begin
				$display("%0t: unexpected expiry slot=%0d is_task=%0d last=%0d",
					$time, slot, is_task, last);
				errors++;
				return;
			end
			want = pending_expiries.pop_front();
			checked++;
			if (slot !== want.slot) begin
				$display("%0t: expired_slot expected %0d actual %0d", $time, want.slot, slot);
				errors++;
			end
			if (is_task !== want.is_task) begin
				$display("%0t: expired_is_task expected %0d actual %0d (slot %0d)",
					$time, want.is_task, is_task, want.slot);
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: last_expiry expected %0d actual %0d (slot %0d)",
					$time, want.last, last, want.slot);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sttb_cmd_if cmd_ch ();
	sttb_exp_if exp_ch ();

	software_timer_and_task_bank_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.exp    (exp_ch)
	);

	expiry_scoreboard sb;
	int               stall_pct = STALL_PCT;
	bit               calm;
	int               sent;
	int               quiet_cycles;

	always #4 clk = ~clk;

	// expiry sink: ready drops at random unless a calm stretch is running
	initial begin
		exp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			exp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// sample both channels at the edge, feed the scoreboard, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready)
				sb.note_request(cmd_ch.action, cmd_ch.slot, cmd_ch.period_ms, cmd_ch.repeat_req);
			if (exp_ch.valid && exp_ch.ready)
				sb.check_expiry(exp_ch.expired_slot, exp_ch.expired_is_task, exp_ch.last_expiry);
			if ((cmd_ch.valid && cmd_ch.ready) || (exp_ch.valid && exp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
				$display("FAIL software_timer_and_task_bank_unit");
				$finish;
			end
		end
	end

	// drive one command request and hold it until the block takes it
	task automatic issue(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] slot,
			input logic [PERIOD_W-1:0] period, input logic rep);
		if (!calm && $urandom_range(0, 99) < STALL_PCT) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.action     <= act;
		cmd_ch.slot       <= slot;
		cmd_ch.period_ms  <= period;
		cmd_ch.repeat_req <= rep;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		sent++;
	endtask

	// tick with junk in the unused fields
	task automatic tick();
		issue(ACT_TICK, SLOT_W'($urandom_range(0, 7)), PERIOD_W'($urandom_range(0, 65535)),
			1'($urandom_range(0, 1)));
	endtask

	// mostly short periods so slots fire often, now and then zero or a wide value
	function automatic logic [PERIOD_W-1:0] pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return PERIOD_W'($urandom_range(1, 3));
		else if (r < 85)
			return '0;
		else if (r < 95)
			return PERIOD_W'($urandom_range(4, 8));
		else
			return PERIOD_W'($urandom_range(0, 65535));
	endfunction

	// every slot armed with the same period, so one tick reports the whole bank
	task automatic fill_bank();
		for (int i = 0; i < NUM_TIMERS; i++)
			issue(ACT_START_TIMER, SLOT_W'(i), PERIOD_W'(1), 1'($urandom_range(0, 1)));
		for (int i = 0; i < NUM_TASKS; i++)
			issue(ACT_START_TASK, SLOT_W'(i), PERIOD_W'(1), 1'($urandom_range(0, 1)));
		repeat (TENTHS_PER_MS) tick();
	endtask

	// hold the command side off until every predicted expiry has come out
	task automatic drain_expiries();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_expiries.size() != 0) @(posedge clk);
	endtask

	initial begin
		int  r;
		bit  mid_drain_done;
		sb = new();
		arst_n            = 1'b0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.action     = ACT_TICK;
		cmd_ch.slot       = '0;
		cmd_ch.period_ms  = '0;
		cmd_ch.repeat_req = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: edge slots, one-shot against repeat, zero and maximum period,
		// unknown actions, then enough ticks for the 1 ms slots to fire together
		issue(ACT_START_TIMER, SLOT_W'(0), PERIOD_W'(1), 1'b0);
		issue(ACT_START_TIMER, SLOT_W'(7), PERIOD_W'(1), 1'b1);
		issue(ACT_START_TASK, SLOT_W'(0), PERIOD_W'(1), 1'b0);
		issue(ACT_START_TASK, SLOT_W'(7), PERIOD_W'(2), 1'b1);
		issue(ACT_START_TIMER, SLOT_W'(3), '0, 1'b1);
		issue(ACT_START_TASK, SLOT_W'(5), '1, 1'b0);
		issue(ACTION_W'(ACT_STOP_TASK) + ACTION_W'(1), SLOT_W'(7), '1, 1'b1);
		issue(ACTION_W'(ACT_STOP_TASK) + ACTION_W'(2), SLOT_W'(2), PERIOD_W'(1), 1'b0);
		issue(ACTION_W'(ACT_STOP_TASK) + ACTION_W'(3), SLOT_W'(5), PERIOD_W'(16'h8000), 1'b1);
		repeat (12) tick();
		// stop keeps the count frozen; the restart reloads it
		issue(ACT_STOP_TIMER, SLOT_W'(7), '0, 1'b0);
		issue(ACT_STOP_TASK, SLOT_W'(5), '0, 1'b0);
		issue(ACT_START_TIMER, SLOT_W'(3), PERIOD_W'(1), 1'b0);
		drain_expiries();

		// random: the full bank once up front, then a weighted mix of requests
		fill_bank();
		while (sent < RANDOM_ITEMS) begin
			calm      = (sent >= 120 && sent < 180);
			stall_pct = calm ? 0 : STALL_PCT;
			if (!mid_drain_done && sent >= 200) begin
				drain_expiries();
				mid_drain_done = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 58)
				tick();
			else if (r < 70)
				issue(ACT_START_TIMER, SLOT_W'($urandom_range(0, 7)), pick_period(),
					1'($urandom_range(0, 1)));
			else if (r < 79)
				issue(ACT_START_TASK, SLOT_W'($urandom_range(0, 7)), pick_period(),
					1'($urandom_range(0, 1)));
			else if (r < 85)
				issue(ACT_STOP_TIMER, SLOT_W'($urandom_range(0, 7)),
					PERIOD_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
			else if (r < 91)
				issue(ACT_STOP_TASK, SLOT_W'($urandom_range(0, 7)),
					PERIOD_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
			else if (r < 94)
				issue(ACTION_W'(ACT_STOP_TASK) + ACTION_W'($urandom_range(1, 3)),
					SLOT_W'($urandom_range(0, 7)), PERIOD_W'($urandom_range(0, 65535)),
					1'($urandom_range(0, 1)));
			else if (r < 97)
				repeat ($urandom_range(10, 30)) tick();
			else
				fill_bank();
		end

		// wind down: let every expiry out, then watch for strays
		calm         = 1'b1;
		stall_pct    = 0;
		drain_expiries();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d ticks and %0d start/stop requests, %0d expiries checked",
			sb.ticks, sb.commands, sb.checked);
		$display("widest tick reported %0d expiries, %0d mismatches seen",
			sb.widest_tick, sb.errors);
		if (sb.errors == 0 && sb.pending_expiries.size() == 0) begin
			$display("PASS software_timer_and_task_bank_unit");
		end else begin
			$display("FAIL software_timer_and_task_bank_unit");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/sttb_pkg.sv
rtl/sttb_cmd_if.sv
rtl/sttb_exp_if.sv
rtl/sttb_alu.sv
rtl/sttb_out_reg.sv
rtl/software_timer_and_task_bank_unit.sv
rtl/sttb_checker.sv
verif/tb_software_timer_and_task_bank_unit.sv
